### design/prpd_pkg.sv
`timescale 1ns / 1ps

package prpd_pkg;

  // fixed field and bus widths
  localparam int DATA_W = 32;
  localparam int ADDR_W = 3;
  localparam int VALUE_WIDTH_DEF = 32;

  typedef logic [DATA_W-1:0] data_t;

  // register indexes (paddr bit 2 upwards)
  localparam logic REG_PAIR_DISTANCE = 1'b0;

  localparam data_t PAIR_DISTANCE_RESET = data_t'(2);
  localparam data_t COUNT_MAX = '1;

  // status from the primality unit back to the sequencer
  typedef struct packed {
    logic done;
    logic is_prime;
  } prime_status_t;

endpackage

### design/prpd_if.sv
`timescale 1ns / 1ps

// candidate channel
interface prpd_cand_if;
  logic valid;
  logic ready;
  prpd_pkg::data_t candidate;

  modport source (output valid, output candidate, input ready);
  modport sink (input valid, input candidate, output ready);
endinterface

// result channel
interface prpd_res_if;
  logic valid;
  logic ready;
  logic pair_found;
  logic first_is_prime;
  prpd_pkg::data_t first_value;
  prpd_pkg::data_t first_half;
  prpd_pkg::data_t partner_value;
  prpd_pkg::data_t partner_half;
  prpd_pkg::data_t pairs_so_far;
  logic out_of_range;

  modport source (output valid, output pair_found, output first_is_prime,
                  output first_value, output first_half, output partner_value,
                  output partner_half, output pairs_so_far, output out_of_range,
                  input ready);
  modport sink (input valid, input pair_found, input first_is_prime,
                input first_value, input first_half, input partner_value,
                input partner_half, input pairs_so_far, input out_of_range,
                output ready);
endinterface

### design/prpd_prime_unit.sv
`timescale 1ns / 1ps

// primality by trial division with odd divisors, one remainder bit a cycle
module prpd_prime_unit #(
  parameter int VALUE_WIDTH = prpd_pkg::VALUE_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [VALUE_WIDTH-1:0]     value,
  output prpd_pkg::prime_status_t    status
);

  localparam int IDX_W = $clog2(VALUE_WIDTH);
  localparam logic [IDX_W-1:0] TOP_BIT = IDX_W'(VALUE_WIDTH - 1);

  localparam logic [1:0] P_IDLE  = 2'd0;
  localparam logic [1:0] P_CHECK = 2'd1;
  localparam logic [1:0] P_DIV   = 2'd2;

  logic [1:0]             st;
  logic [VALUE_WIDTH-1:0] v;
  logic [VALUE_WIDTH-1:0] d;
  logic [VALUE_WIDTH:0]   sq;
  logic [VALUE_WIDTH-1:0] r;
  logic [IDX_W-1:0]       idx;
  logic                   done;
  logic                   is_prime;

  logic [VALUE_WIDTH:0]   shifted;
  logic                   fits;
  logic [VALUE_WIDTH-1:0] rem_next;
  logic [VALUE_WIDTH:0]   sq_next;

  // shared subtract and compare: one restoring division step
  always_comb begin
    shifted  = {r, v[idx]};
    fits     = shifted >= {1'b0, d};
    rem_next = fits ? VALUE_WIDTH'(shifted - {1'b0, d}) : shifted[VALUE_WIDTH-1:0];
    // (d+2)^2 = d^2 + 4d + 4
    sq_next  = (VALUE_WIDTH+1)'(sq + {d, 2'b00} + (VALUE_WIDTH+1)'(4));
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      st   <= P_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (st)
        P_IDLE: begin
          if (start) begin
            v <= value;
            if (value < VALUE_WIDTH'(2)) begin
              done     <= 1'b1;
              is_prime <= 1'b0;
            end else if (value < VALUE_WIDTH'(4)) begin
              done     <= 1'b1;
              is_prime <= 1'b1;
            end else if (!value[0]) begin
              done     <= 1'b1;
              is_prime <= 1'b0;
            end else begin
              d  <= VALUE_WIDTH'(3);
              sq <= (VALUE_WIDTH+1)'(9);
              st <= P_CHECK;
            end
          end
        end
        P_CHECK: begin
          // divisor past the square root: no factor found
          if (sq > {1'b0, v}) begin
            done     <= 1'b1;
            is_prime <= 1'b1;
            st       <= P_IDLE;
          end else begin
            r   <= '0;
            idx <= TOP_BIT;
            st  <= P_DIV;
          end
        end
        P_DIV: begin
          r   <= rem_next;
          idx <= idx - IDX_W'(1);
          if (idx == '0) begin
            if (rem_next == '0) begin
              done     <= 1'b1;
              is_prime <= 1'b0;
              st       <= P_IDLE;
            end else begin
              d  <= d + VALUE_WIDTH'(2);
              sq <= sq_next;
              st <= P_CHECK;
            end
          end
        end
        default: st <= P_IDLE;
      endcase
    end
  end

  assign status.done     = done;
  assign status.is_prime = is_prime;

  // a new test only starts when the unit is free
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> st == P_IDLE) else $error("prime unit started while busy");

  // trial divisors stay odd
  a_odd_divisor: assert property (@(posedge clk) disable iff (rst)
    st == P_CHECK |-> d[0]) else $error("even trial divisor");

endmodule

### design/prime_pair_at_distance_test.sv
`timescale 1ns / 1ps

// channel    dir  handshake        payload
// cand_ch    in   valid/ready      candidate
// res_ch     out  valid/ready      pair_found .. out_of_range (8 fields)
// apb        in   psel/penable     paddr/pwdata write, prdata read
//
// each request is tested by trial division over odd divisors up to its square
// root, one remainder bit per cycle in a single shared subtractor, with up to
// 2^(VALUE_WIDTH/2-1) divisors per value
// the partner is tested only when the candidate is prime and in range
// cand_ch.ready is high only while no request is in work; a finished result
// waits in the output register while the next request is taken
// rst is synchronous: pair_distance returns to 2, the pair count to 0
module prime_pair_at_distance_test #(
  parameter int VALUE_WIDTH = prpd_pkg::VALUE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  prpd_cand_if.sink                     cand_ch,
  prpd_res_if.source                    res_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [prpd_pkg::ADDR_W-1:0]   paddr,
  input  prpd_pkg::data_t               pwdata,
  output prpd_pkg::data_t               prdata,
  output logic                          pready
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_FIRST  = 2'd1;
  localparam logic [1:0] S_SECOND = 2'd2;
  localparam logic [1:0] S_EMIT   = 2'd3;

  logic [1:0]              state;
  prpd_pkg::data_t         pair_distance;
  prpd_pkg::data_t         pair_counter;
  prpd_pkg::data_t         pair_counter_next;
  logic [VALUE_WIDTH-1:0]  cand;
  logic [VALUE_WIDTH:0]    partner;
  logic                    first_p;
  logic                    pair;

  logic                    accept;
  logic                    oor;
  logic                    start;
  logic [VALUE_WIDTH-1:0]  test_value;
  prpd_pkg::prime_status_t status;
  logic                    emit;
  logic [VALUE_WIDTH:0]    cand_inc;
  logic [VALUE_WIDTH:0]    partner_inc;

  logic                    out_valid;
  logic                    out_pair;
  logic                    out_first_p;
  prpd_pkg::data_t         out_first_value;
  prpd_pkg::data_t         out_first_half;
  prpd_pkg::data_t         out_partner_value;
  prpd_pkg::data_t         out_partner_half;
  prpd_pkg::data_t         out_pairs;
  logic                    out_oor;

  // configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[prpd_pkg::ADDR_W-1:2] == prpd_pkg::REG_PAIR_DISTANCE)
                  ? pair_distance : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      pair_distance <= prpd_pkg::PAIR_DISTANCE_RESET;
    end else if (psel && penable && pwrite &&
                 paddr[prpd_pkg::ADDR_W-1:2] == prpd_pkg::REG_PAIR_DISTANCE) begin
      pair_distance <= pwdata;
    end
  end

  // request intake and test dispatch
  assign cand_ch.ready = (state == S_IDLE);
  assign accept = cand_ch.valid && cand_ch.ready;
  assign oor    = partner[VALUE_WIDTH];
  assign start  = accept ||
                  (state == S_FIRST && status.done && status.is_prime && !oor);
  assign test_value = (state == S_IDLE) ? cand_ch.candidate[VALUE_WIDTH-1:0]
                                        : partner[VALUE_WIDTH-1:0];

  prpd_prime_unit #(.VALUE_WIDTH(VALUE_WIDTH)) u_prime (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .value  (test_value),
    .status (status)
  );

  // result formatting
  assign emit = (state == S_EMIT) && (!out_valid || res_ch.ready);
  assign cand_inc    = {1'b0, cand} + (VALUE_WIDTH+1)'(1);
  assign partner_inc = {1'b0, partner[VALUE_WIDTH-1:0]} + (VALUE_WIDTH+1)'(1);

  always_comb begin
    pair_counter_next = pair_counter;
    if (pair && pair_counter != prpd_pkg::COUNT_MAX) begin
      pair_counter_next = pair_counter + prpd_pkg::data_t'(1);
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      pair_counter <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            cand    <= cand_ch.candidate[VALUE_WIDTH-1:0];
            partner <= {1'b0, cand_ch.candidate[VALUE_WIDTH-1:0]} +
                       {1'b0, pair_distance[VALUE_WIDTH-1:0]};
            state   <= S_FIRST;
          end
        end
        S_FIRST: begin
          if (status.done) begin
            first_p <= status.is_prime;
            pair    <= 1'b0;
            state   <= (status.is_prime && !oor) ? S_SECOND : S_EMIT;
          end
        end
        S_SECOND: begin
          if (status.done) begin
            pair  <= status.is_prime;
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (emit) begin
            pair_counter <= pair_counter_next;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (res_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_pair          <= pair;
      out_first_p       <= first_p;
      out_first_value   <= prpd_pkg::data_t'(cand);
      out_first_half    <= prpd_pkg::data_t'(cand_inc[VALUE_WIDTH:1]);
      out_partner_value <= oor ? '0 : prpd_pkg::data_t'(partner[VALUE_WIDTH-1:0]);
      out_partner_half  <= oor ? '0 : prpd_pkg::data_t'(partner_inc[VALUE_WIDTH:1]);
      out_pairs         <= pair_counter_next;
      out_oor           <= oor;
    end
  end

  assign res_ch.valid          = out_valid;
  assign res_ch.pair_found     = out_pair;
  assign res_ch.first_is_prime = out_first_p;
  assign res_ch.first_value    = out_first_value;
  assign res_ch.first_half     = out_first_half;
  assign res_ch.partner_value  = out_partner_value;
  assign res_ch.partner_half   = out_partner_half;
  assign res_ch.pairs_so_far   = out_pairs;
  assign res_ch.out_of_range   = out_oor;

  // a reported pair needs a prime candidate and an in-range partner
  a_pair_consistent: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_pair |-> out_first_p && !out_oor && out_pairs != '0)
    else $error("pair reported without its conditions");

  // an accepted request always starts the first test
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == S_FIRST) else $error("request accepted without a test");

  // the pair count never goes down
  a_count_monotonic: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> pair_counter >= $past(pair_counter))
    else $error("pair count decreased");

endmodule

### dv/tb.sv
`timescale 1ns / 1ps

module tb;

  // unmapped register index, writes to it must be dropped
  localparam logic REG_SPARE = 1'b1;
  // budget of odd divisors per random request, keeps the run short
  localparam int unsigned DIVISOR_BUDGET = 300;

  typedef struct {
    logic pair_found;
    logic first_is_prime;
    prpd_pkg::data_t first_value;
    prpd_pkg::data_t first_half;
    prpd_pkg::data_t partner_value;
    prpd_pkg::data_t partner_half;
    prpd_pkg::data_t pairs_so_far;
    logic out_of_range;
  } pair_report_t;

  logic clk = 1'b0;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [prpd_pkg::ADDR_W-1:0] paddr;
  prpd_pkg::data_t pwdata;
  prpd_pkg::data_t prdata;
  logic pready;

  prpd_cand_if cand_ch ();
  prpd_res_if res_ch ();

  prime_pair_at_distance_test uut (
    .clk(clk),
    .rst(rst),
    .cand_ch(cand_ch),
    .res_ch(res_ch),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  // predicted register and counter state
  prpd_pkg::data_t pair_gap = prpd_pkg::PAIR_DISTANCE_RESET;
  prpd_pkg::data_t pair_total = '0;
  pair_report_t pair_reports_q[$];

  int fault_count = 0;
  int burst_left = 0;
  int rx_hold_cycles = 0;
  logic [7:0] rx_pattern = 8'hFF;
  logic [2:0] rx_phase = '0;

  always #1 clk = ~clk;

  // trial division over odd divisors, also counts the divisors tried
  function automatic bit prime_by_division(input longint unsigned v,
                                           output int unsigned steps);
    longint unsigned d;
    steps = 0;
    if (v < 2) return 1'b0;
    if (v < 4) return 1'b1;
    if (v[0] == 1'b0) return 1'b0;
    for (d = 3; d * d <= v; d += 2) begin
      steps++;
      if (v % d == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  // expected report for one request, advances the pair count
  function automatic pair_report_t predict_pair_report(prpd_pkg::data_t cand);
    pair_report_t r;
    logic [32:0] partner;
    logic [32:0] bumped;
    int unsigned steps;
    bit first_p;
    bit partner_p;
    partner = {1'b0, cand} + {1'b0, pair_gap};
    first_p = prime_by_division(cand, steps);
    partner_p = 1'b0;
    if (!partner[32] && first_p) partner_p = prime_by_division(partner, steps);
    if (partner_p && pair_total != prpd_pkg::COUNT_MAX) pair_total++;
    bumped = {1'b0, cand} + 33'd1;
    r.pair_found = partner_p;
    r.first_is_prime = first_p;
    r.first_value = cand;
    r.first_half = bumped[32:1];
    r.out_of_range = partner[32];
    if (partner[32]) begin
      r.partner_value = '0;
      r.partner_half = '0;
    end else begin
      bumped = partner + 33'd1;
      r.partner_value = partner[31:0];
      r.partner_half = bumped[32:1];
    end
    r.pairs_so_far = pair_total;
    return r;
  endfunction

  // divisors the block will walk for this request at the current distance
  function automatic int unsigned division_cost(prpd_pkg::data_t cand);
    logic [32:0] partner;
    int unsigned s1;
    int unsigned s2;
    bit p;
    s2 = 0;
    partner = {1'b0, cand} + {1'b0, pair_gap};
    p = prime_by_division(cand, s1);
    if (p && !partner[32]) void'(prime_by_division(partner, s2));
    return s1 + s2;
  endfunction

  // mostly small values, large ones forced to have a tiny factor
  function automatic prpd_pkg::data_t random_candidate();
    prpd_pkg::data_t c;
    int unsigned pick;
    do begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        c = $urandom_range(0, 4095);
      end else if (pick < 70) begin
        c = $urandom_range(0, 65535);
      end else if (pick < 85) begin
        c = $urandom;
        c[0] = 1'b0;
      end else begin
        c = 3 * $urandom_range(0, 32'h5555_5555);
      end
    end while (division_cost(c) > DIVISOR_BUDGET);
    return c;
  endfunction

  task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      fault_count++;
      if (fault_count <= 10)
        $display("mismatch %s: expected %h, got %h", name, want, got);
    end
  endtask

  // compare one delivered report with the oldest prediction
  task automatic check_pair_report();
    pair_report_t want;
    if (pair_reports_q.size() == 0) begin
      fault_count++;
      if (fault_count <= 10)
        $display("unexpected report for candidate %h", res_ch.first_value);
    end else begin
      want = pair_reports_q.pop_front();
      compare_field("pair_found", want.pair_found, res_ch.pair_found);
      compare_field("first_is_prime", want.first_is_prime, res_ch.first_is_prime);
      compare_field("first_value", want.first_value, res_ch.first_value);
      compare_field("first_half", want.first_half, res_ch.first_half);
      compare_field("partner_value", want.partner_value, res_ch.partner_value);
      compare_field("partner_half", want.partner_half, res_ch.partner_half);
      compare_field("pairs_so_far", want.pairs_so_far, res_ch.pairs_so_far);
      compare_field("out_of_range", want.out_of_range, res_ch.out_of_range);
    end
  endtask

  // receiver: checks reports, stalls on a rolling byte pattern or a long hold
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) check_pair_report();
      if (rx_hold_cycles > 0) begin
        res_ch.ready <= 1'b0;
        rx_hold_cycles--;
      end else begin
        if (rx_phase == 3'd0)
          rx_pattern = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom);
        res_ch.ready <= rx_pattern[rx_phase];
        rx_phase = rx_phase + 3'd1;
      end
    end
  end

  task automatic apb_write(logic reg_idx, prpd_pkg::data_t value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {reg_idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    if (reg_idx == prpd_pkg::REG_PAIR_DISTANCE) pair_gap = value;
    @(posedge clk);
  endtask

  task automatic apb_read(logic reg_idx, output prpd_pkg::data_t value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {reg_idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    value = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_distance_reg();
    prpd_pkg::data_t got;
    apb_read(prpd_pkg::REG_PAIR_DISTANCE, got);
    compare_field("pair_distance", pair_gap, got);
  endtask

  // offer one request in bursts, predict its report on acceptance
  task automatic send_candidate(prpd_pkg::data_t value);
    if (burst_left == 0) begin
      repeat (($urandom_range(0, 9) == 0) ? 40 : $urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 16);
    end
    cand_ch.valid <= 1'b1;
    cand_ch.candidate <= value;
    @(posedge clk);
    while (!cand_ch.ready) @(posedge clk);
    pair_reports_q.push_back(predict_pair_report(value));
    burst_left--;
    if (burst_left == 0) cand_ch.valid <= 1'b0;
  endtask

  // stop offering and wait until every report is in
  task automatic settle_block();
    if (burst_left != 0) cand_ch.valid <= 1'b0;
    burst_left = 0;
    while (pair_reports_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic test_reset_state();
    check_distance_reg();
  endtask

  // boundary values and small primes at the reset distance
  task automatic test_directed_candidates();
    prpd_pkg::data_t picks[] = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd9,
                                 32'd11, 32'd25, 32'd29, 32'd1019, 32'd1048573,
                                 32'h8000_0000, 32'hFFFF_FFFC, 32'hFFFF_FFFE,
                                 32'hFFFF_FFFF};
    foreach (picks[i]) send_candidate(picks[i]);
    settle_block();
  endtask

  // zero, one and near-full distances, overflow edge, unmapped register
  task automatic test_distance_settings();
    apb_write(prpd_pkg::REG_PAIR_DISTANCE, 32'd0);
    send_candidate(32'd7);
    send_candidate(32'd8);
    settle_block();
    apb_write(prpd_pkg::REG_PAIR_DISTANCE, 32'd1);
    send_candidate(32'd2);
    send_candidate(32'd3);
    settle_block();
    apb_write(prpd_pkg::REG_PAIR_DISTANCE, 32'hFFFF_FFF0);
    send_candidate(32'd17);
    send_candidate(32'd15);
    send_candidate(32'd16);
    settle_block();
    apb_write(prpd_pkg::REG_PAIR_DISTANCE, 32'hFFFF_FFFF);
    check_distance_reg();
    send_candidate(32'd0);
    send_candidate(32'd1);
    send_candidate(32'd2);
    settle_block();
    apb_write(REG_SPARE, 32'd4);
    check_distance_reg();
    send_candidate(32'd3);
    settle_block();
    apb_write(prpd_pkg::REG_PAIR_DISTANCE, 32'd6);
    check_distance_reg();
  endtask

  // long receiver hold while requests keep coming, then a full pause
  task automatic test_backpressure();
    rx_hold_cycles = 400;
    burst_left = 10;
    repeat (10) send_candidate($urandom_range(0, 255));
    settle_block();
    repeat (4) send_candidate($urandom_range(0, 255));
    settle_block();
  endtask

  task automatic test_random_candidates();
    prpd_pkg::data_t gaps[5];
    gaps[0] = 32'd2;
    gaps[1] = 32'd4;
    gaps[2] = $urandom_range(0, 255);
    gaps[3] = $urandom;
    gaps[4] = ~($urandom_range(0, 65535));
    foreach (gaps[i]) begin
      apb_write(prpd_pkg::REG_PAIR_DISTANCE, gaps[i]);
      repeat (12) send_candidate(random_candidate());
      settle_block();
    end
  endtask

  // run limit
  initial begin
    #10_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    cand_ch.valid <= 1'b0;
    cand_ch.candidate <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_state();
    test_directed_candidates();
    test_distance_settings();
    test_backpressure();
    test_random_candidates();

    settle_block();
    repeat (50) @(posedge clk);
    if (fault_count == 0 && pair_reports_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### files.f
design/prpd_pkg.sv
design/prpd_if.sv
design/prpd_prime_unit.sv
design/prime_pair_at_distance_test.sv
dv/tb.sv
